// ----- rtl/vms_pkg.sv -----
// vms_pkg: types, constants and register codes shared by the voice quality
// score pipeline. No dependencies.
`default_nettype none

package vms_pkg;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_SIMPLIFIED = 2'd0,
      CSR_WIDEBAND   = 2'd1,
      CSR_CODEC_IE   = 2'd2,
      CSR_LOSS_BPL   = 2'd3
   } csr_index_type;

   localparam logic [14:0] LOSS_MAX = 15'd25600;
   localparam logic [14:0] IE_MAX   = 15'd24320;
   localparam logic [14:0] MOS_ONE  = 15'd4096;
   localparam logic [14:0] MOS_MAX  = 15'd18432;
   localparam logic [15:0] RO_NB    = 16'd23859;
   localparam logic [15:0] RO_WB    = 16'd33024;

   // Delay impairment knee (177.3 ms in 1/32 ms) and its offset in 1/32000 units
   localparam logic [17:0] TA_KNEE  = 18'd5674;
   localparam logic [24:0] KNEE_OFS = 25'd624096;

   // Linear formula in 1/2560000 units
   localparam logic signed [26:0] LIN_BASE  = 27'sd11520000;
   localparam logic signed [26:0] LIN_FLOOR = 27'sd2560000;

   // Polynomial: constant term plus rounding half, linear coefficient
   localparam logic signed [47:0] POLY_BASE = 48'sd16779264000000;
   localparam logic [31:0]        POLY_LIN  = 32'd2293760000;
   localparam logic [15:0]        R_FULL    = 16'd25600;
   localparam logic [16:0]        R_MID     = 17'd15360;

   // Reciprocals: floor(2^k / d)
   localparam logic [25:0] RCP_125   = 26'd34359738;    // k = 32
   localparam logic [24:0] RCP_625   = 25'd27487790;    // k = 34
   localparam logic [22:0] RCP_129   = 23'd8323580;     // k = 30
   localparam logic [30:0] RCP_15625 = 31'd1125899906;  // k = 44

   localparam int NUM_W  = 30;
   localparam int DEN_W  = 16;
   localparam int QUOT_W = 15;
   localparam int LANES  = 2;

   typedef struct packed {
      logic [14:0] ie;
      logic [17:0] id;
      logic [14:0] lq_lin;
      logic [14:0] cq_lin;
   } div_side_type;

   typedef struct packed {
      logic signed [16:0] r_lq;
      logic [14:0]        lq_lin;
      logic [14:0]        cq_lin;
   } r2m_side_type;

endpackage

`default_nettype wire

// ----- rtl/vms_div.sv -----
// vms_div: pipelined restoring divider, one quotient bit per stage, with a
// sideband carried alongside. Depends on vms_pkg.
`default_nettype none

module vms_div #(
   parameter type side_type = logic
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire logic [vms_pkg::NUM_W-1:0]       in_num,
   input  wire logic [vms_pkg::DEN_W-1:0]       in_den,
   input  wire side_type                        in_side,
   output logic                                 out_valid,
   output logic [vms_pkg::QUOT_W-1:0]           out_quot,
   output side_type                             out_side
);

   localparam int QW = vms_pkg::QUOT_W;
   localparam int DW = vms_pkg::DEN_W;

   logic [QW:0]   valid_ff;
   logic [DW-1:0] rem_ff  [QW+1];
   logic [QW-1:0] low_ff  [QW+1];
   logic [QW-1:0] quot_ff [QW+1];
   logic [DW-1:0] den_ff  [QW+1];
   side_type      side_ff [QW+1];

   logic [DW-1:0] rem_in  [QW];
   logic [QW-1:0] low_in  [QW];
   logic [QW-1:0] quot_in [QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DW'(in_num[vms_pkg::NUM_W-1:QW]);
         low_ff[0]  <= in_num[QW-1:0];
         quot_ff[0] <= '0;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_bit
      logic [DW:0] trial;
      logic        ge;

      always_comb begin
         trial      = {rem_ff[k], low_ff[k][QW-1]};
         ge         = trial >= {1'b0, den_ff[k]};
         rem_in[k]  = ge ? DW'(trial - {1'b0, den_ff[k]}) : trial[DW-1:0];
         low_in[k]  = {low_ff[k][QW-2:0], 1'b0};
         quot_in[k] = {quot_ff[k][QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in[k];
            low_ff[k+1]  <= low_in[k];
            quot_ff[k+1] <= quot_in[k];
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_quot  = quot_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

`default_nettype wire

// ----- rtl/vms_r2mos.sv -----
// vms_r2mos: pipelined R factor to MOS mapping, several lanes sharing one
// valid and sideband line, nine register stages. Depends on vms_pkg.
`default_nettype none

module vms_r2mos #(
   parameter type side_type = logic
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                wideband,
   input  wire logic                                in_valid,
   input  wire logic [vms_pkg::LANES-1:0][18:0]     in_r,
   input  wire side_type                            in_side,
   output logic                                     out_valid,
   output logic [vms_pkg::LANES-1:0][14:0]          out_mos,
   output side_type                                 out_side
);

   localparam int DEPTH = 9;

   logic [DEPTH-1:0] valid_ff;
   side_type         side_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < DEPTH; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   for (genvar l = 0; l < vms_pkg::LANES; l++) begin : g_lane
      // stage 1: capture
      logic signed [18:0] r_ff;
      // stage 2: sign and wideband scaling numerator
      logic        s2_pos_ff;
      logic [15:0] s2_r_ff;
      logic [21:0] s2_y_ff;
      // stage 3: quotient estimate
      logic        s3_pos_ff;
      logic [15:0] s3_r_ff;
      logic [21:0] s3_y_ff;
      logic [15:0] s3_q_ff;
      // stage 4: normalised R and range flags
      logic        s4_zero_ff, s4_full_ff;
      logic [15:0] s4_rr_ff;
      // stage 5: partial products
      logic        s5_zero_ff, s5_full_ff;
      logic [27:0] s5_a_ff;
      logic signed [16:0] s5_b_ff;
      logic [45:0] s5_lin_ff;
      // stage 6: cubic term
      logic        s6_zero_ff, s6_full_ff;
      logic signed [45:0] s6_p_ff;
      logic [45:0] s6_lin_ff;
      // stage 7: sum
      logic        s7_zero_ff, s7_full_ff, s7_neg_ff;
      logic [28:0] s7_x_ff;
      // stage 8: quotient estimate
      logic        s8_zero_ff, s8_full_ff, s8_neg_ff;
      logic [28:0] s8_x_ff;
      logic [15:0] s8_q_ff;
      // stage 9: result
      logic [14:0] mos_ff;

      logic [21:0] y_in;
      logic [15:0] qw_in;
      logic [21:0] remw;
      logic [15:0] qwc;
      logic [15:0] rr_in;
      logic signed [47:0] sum_in;
      logic signed [47:0] p_ext;
      logic [15:0] q8_in;
      logic [28:0] rem8;
      logic [15:0] q9;
      logic [14:0] mos_in;

      always_comb begin
         y_in   = 22'(r_ff[15:0]) * 22'd100 + 22'd64;
         qw_in  = 16'((45'(s2_y_ff) * 45'(vms_pkg::RCP_129)) >> 30);
         remw   = s3_y_ff - 22'(s3_q_ff) * 22'd129;
         qwc    = (remw >= 22'd129) ? s3_q_ff + 16'd1 : s3_q_ff;
         rr_in  = wideband ? qwc : s3_r_ff;
         p_ext  = 48'(s6_p_ff);
         sum_in = vms_pkg::POLY_BASE + $signed({2'b00, s6_lin_ff})
                  + (p_ext <<< 3) - p_ext;
         q8_in  = 16'((60'(s7_x_ff) * 60'(vms_pkg::RCP_15625)) >> 44);
         rem8   = s8_x_ff - 29'(s8_q_ff) * 29'd15625;
         q9     = (rem8 >= 29'd15625) ? s8_q_ff + 16'd1 : s8_q_ff;
         if (s8_zero_ff || s8_neg_ff) begin
            mos_in = vms_pkg::MOS_ONE;
         end else if (s8_full_ff || q9 > 16'(vms_pkg::MOS_MAX)) begin
            mos_in = vms_pkg::MOS_MAX;
         end else if (q9 < 16'(vms_pkg::MOS_ONE)) begin
            mos_in = vms_pkg::MOS_ONE;
         end else begin
            mos_in = q9[14:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff       <= $signed(in_r[l]);
            s2_pos_ff  <= r_ff > 19'sd0;
            s2_r_ff    <= r_ff[15:0];
            s2_y_ff    <= y_in;
            s3_pos_ff  <= s2_pos_ff;
            s3_r_ff    <= s2_r_ff;
            s3_y_ff    <= s2_y_ff;
            s3_q_ff    <= qw_in;
            s4_zero_ff <= !s3_pos_ff;
            s4_full_ff <= rr_in >= vms_pkg::R_FULL;
            s4_rr_ff   <= rr_in;
            s5_zero_ff <= s4_zero_ff;
            s5_full_ff <= s4_full_ff;
            s5_a_ff    <= 28'(s4_rr_ff) * 28'(vms_pkg::R_FULL - s4_rr_ff);
            s5_b_ff    <= $signed({1'b0, s4_rr_ff}) - $signed(vms_pkg::R_MID);
            s5_lin_ff  <= 46'(s4_rr_ff) * 46'(vms_pkg::POLY_LIN);
            s6_zero_ff <= s5_zero_ff;
            s6_full_ff <= s5_full_ff;
            s6_p_ff    <= 46'($signed({1'b0, s5_a_ff}) * s5_b_ff);
            s6_lin_ff  <= s5_lin_ff;
            s7_zero_ff <= s6_zero_ff;
            s7_full_ff <= s6_full_ff;
            s7_neg_ff  <= sum_in < 48'sd0;
            s7_x_ff    <= sum_in[46:18];
            s8_zero_ff <= s7_zero_ff;
            s8_full_ff <= s7_full_ff;
            s8_neg_ff  <= s7_neg_ff;
            s8_x_ff    <= s7_x_ff;
            s8_q_ff    <= q8_in;
            mos_ff     <= mos_in;
         end
      end

      assign out_mos[l] = mos_ff;
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_side  = side_ff[DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/voip_mos_score_unit.sv -----
// voip_mos_score_unit: top level of the voice quality score pipeline.
// Depends on vms_pkg, vms_div and vms_r2mos.
//
//   channel | ports  | direction | beat
//   --------+--------+-----------+----------------------------------------
//   request | req_*  | in        | loss, jitter, buffer depth, round trip
//   result  | rsp_*  | out       | listening MOS, conversational MOS, average
//   config  | csr_*  | in        | register index and write data
//
// One beat enters per cycle while no result is held; each request passes
// 4 front stages, 16 divider stages, 9 mapping stages and 1 output register.
// The 16-stage loss-impairment divider sets the depth.
// A stalled result holds the whole pipeline; req_ready is low only then.
// Reset clears all valid bits and restores the register defaults.
`default_nettype none

module voip_mos_score_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [14:0]        req_loss_percent,
   input  wire logic [15:0]        req_jitter_time,
   input  wire logic [15:0]        req_buffer_depth,
   input  wire logic [15:0]        req_round_trip,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [14:0]             rsp_mos_listening,
   output logic [14:0]             rsp_mos_conversational,
   output logic signed [16:0]      rsp_average_quantity,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [14:0]        csr_data
);

   function automatic logic [14:0] lin_mos(input logic low, input logic [23:0] t,
                                           input logic [14:0] q0);
      logic [23:0] rem;
      logic [15:0] q;
      begin
         rem = t - 24'(q0) * 24'd625;
         q   = (rem >= 24'd625) ? 16'(q0) + 16'd1 : 16'(q0);
         if (low) begin
            lin_mos = vms_pkg::MOS_ONE;
         end else if (q > 16'(vms_pkg::MOS_MAX)) begin
            lin_mos = vms_pkg::MOS_MAX;
         end else begin
            lin_mos = q[14:0];
         end
      end
   endfunction

   // configuration registers
   logic        simp_ff, wb_ff;
   logic [14:0] ie_ff, bpl_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         simp_ff <= 1'b0;
         wb_ff   <= 1'b0;
         ie_ff   <= 15'd0;
         bpl_ff  <= 15'd1101;
      end else if (csr_valid) begin
         unique case (vms_pkg::csr_index_type'(csr_index))
            vms_pkg::CSR_SIMPLIFIED: simp_ff <= csr_data[0];
            vms_pkg::CSR_WIDEBAND:   wb_ff   <= csr_data[0];
            vms_pkg::CSR_CODEC_IE:   ie_ff   <= csr_data;
            vms_pkg::CSR_LOSS_BPL:   bpl_ff  <= csr_data;
         endcase
      end
   end

   // the whole pipeline advances together unless the result is held
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage 0: capture
   logic        s0_valid_ff;
   logic [14:0] s0_loss_ff;
   logic [15:0] s0_jit_ff, s0_jb_ff, s0_rtt_ff;

   // stage 1: saturate, products
   logic        s1_valid_ff;
   logic [14:0] s1_ie_ff;
   logic [15:0] s1_den_ff;
   logic [29:0] s1_prod_ff;
   logic [17:0] s1_ta_ff;
   logic signed [26:0] s1_nl_ff, s1_nc_ff;

   logic [14:0] loss_sat, ie_sat, bpl_fix, ie_room;
   logic [24:0] pl;
   logic [23:0] pj;
   logic [22:0] pr;
   logic signed [26:0] nl_in;

   always_comb begin
      loss_sat = (s0_loss_ff > vms_pkg::LOSS_MAX) ? vms_pkg::LOSS_MAX : s0_loss_ff;
      ie_sat   = (ie_ff > vms_pkg::IE_MAX) ? vms_pkg::IE_MAX : ie_ff;
      bpl_fix  = (bpl_ff == 15'd0) ? 15'd1 : bpl_ff;
      ie_room  = vms_pkg::IE_MAX - ie_sat;
      pl       = 25'(loss_sat) * 25'd900;
      pj       = 24'(s0_jit_ff) * 24'd144;
      pr       = 23'(s0_rtt_ff) * 23'd80;
      nl_in    = vms_pkg::LIN_BASE - $signed(27'(pl)) - $signed(27'(pj));
   end

   // stage 2: divider numerator, delay term, linear offsets
   logic        s2_valid_ff;
   logic [14:0] s2_ie_ff;
   logic [15:0] s2_den_ff;
   logic [29:0] s2_num_ff;
   logic [24:0] s2_mi_ff;
   logic [23:0] s2_tl_ff, s2_tc_ff;
   logic        s2_lowl_ff, s2_lowc_ff;

   logic        knee;
   logic [24:0] m_in;
   logic        lowl_in, lowc_in;

   always_comb begin
      knee    = s1_ta_ff >= vms_pkg::TA_KNEE;
      m_in    = 25'(s1_ta_ff) * 25'd24
                + (knee ? 25'(s1_ta_ff) * 25'd110 - vms_pkg::KNEE_OFS : 25'd0);
      lowl_in = s1_nl_ff <= vms_pkg::LIN_FLOOR;
      lowc_in = s1_nc_ff <= vms_pkg::LIN_FLOOR;
   end

   // stage 3: reciprocal estimates
   logic        s3_valid_ff;
   logic [14:0] s3_ie_ff;
   logic [15:0] s3_den_ff;
   logic [29:0] s3_num_ff;
   logic [24:0] s3_mi_ff;
   logic [23:0] s3_tl_ff, s3_tc_ff;
   logic        s3_lowl_ff, s3_lowc_ff;
   logic [17:0] s3_qid_ff;
   logic [14:0] s3_ql_ff, s3_qc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_loss_ff <= req_loss_percent;
         s0_jit_ff  <= req_jitter_time;
         s0_jb_ff   <= req_buffer_depth;
         s0_rtt_ff  <= req_round_trip;

         s1_ie_ff   <= ie_sat;
         s1_den_ff  <= 16'(loss_sat) + 16'(bpl_fix);
         s1_prod_ff <= 30'(ie_room) * 30'(loss_sat);
         s1_ta_ff   <= 18'(s0_rtt_ff) + {1'b0, s0_jb_ff, 1'b0};
         s1_nl_ff   <= nl_in;
         s1_nc_ff   <= nl_in - $signed(27'(pr));

         s2_ie_ff   <= s1_ie_ff;
         s2_den_ff  <= s1_den_ff;
         s2_num_ff  <= s1_prod_ff + 30'(s1_den_ff[15:1]);
         s2_mi_ff   <= m_in + 25'd62;
         s2_lowl_ff <= lowl_in;
         s2_lowc_ff <= lowc_in;
         s2_tl_ff   <= lowl_in ? 24'd0 : 24'(s1_nl_ff + 27'sd312);
         s2_tc_ff   <= lowc_in ? 24'd0 : 24'(s1_nc_ff + 27'sd312);

         s3_ie_ff   <= s2_ie_ff;
         s3_den_ff  <= s2_den_ff;
         s3_num_ff  <= s2_num_ff;
         s3_mi_ff   <= s2_mi_ff;
         s3_tl_ff   <= s2_tl_ff;
         s3_tc_ff   <= s2_tc_ff;
         s3_lowl_ff <= s2_lowl_ff;
         s3_lowc_ff <= s2_lowc_ff;
         s3_qid_ff  <= 18'((51'(s2_mi_ff) * 51'(vms_pkg::RCP_125)) >> 32);
         s3_ql_ff   <= 15'((49'(s2_tl_ff) * 49'(vms_pkg::RCP_625)) >> 34);
         s3_qc_ff   <= 15'((49'(s2_tc_ff) * 49'(vms_pkg::RCP_625)) >> 34);
      end
   end

   // corrections feed the divider input stage
   vms_pkg::div_side_type div_side_in, div_side_out;
   logic [24:0] id_rem;
   logic        div_valid;
   logic [14:0] div_quot;

   always_comb begin
      id_rem             = s3_mi_ff - 25'(s3_qid_ff) * 25'd125;
      div_side_in.ie     = s3_ie_ff;
      div_side_in.id     = (id_rem >= 25'd125) ? s3_qid_ff + 18'd1 : s3_qid_ff;
      div_side_in.lq_lin = lin_mos(s3_lowl_ff, s3_tl_ff, s3_ql_ff);
      div_side_in.cq_lin = lin_mos(s3_lowc_ff, s3_tc_ff, s3_qc_ff);
   end

   vms_div #(
      .side_type (vms_pkg::div_side_type)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .in_side   (div_side_in),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side_out)
   );

   // R factors
   logic [15:0]        ie_eff, ro;
   logic signed [16:0] r_lq;
   logic signed [18:0] r_cq;
   vms_pkg::r2m_side_type r2m_side_in, r2m_side_out;
   logic [vms_pkg::LANES-1:0][18:0] r_pair;
   logic [vms_pkg::LANES-1:0][14:0] mos_pair;
   logic r2m_valid;

   always_comb begin
      ie_eff             = 16'(div_side_out.ie) + 16'(div_quot);
      ro                 = wb_ff ? vms_pkg::RO_WB : vms_pkg::RO_NB;
      r_lq               = $signed({1'b0, ro}) - $signed({1'b0, ie_eff});
      r_cq               = 19'(r_lq) - $signed({1'b0, div_side_out.id});
      r_pair[0]          = 19'(r_lq);
      r_pair[1]          = r_cq;
      r2m_side_in.r_lq   = r_lq;
      r2m_side_in.lq_lin = div_side_out.lq_lin;
      r2m_side_in.cq_lin = div_side_out.cq_lin;
   end

   vms_r2mos #(
      .side_type (vms_pkg::r2m_side_type)
   ) u_r2mos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .wideband  (wb_ff),
      .in_valid  (div_valid),
      .in_r      (r_pair),
      .in_side   (r2m_side_in),
      .out_valid (r2m_valid),
      .out_mos   (mos_pair),
      .out_side  (r2m_side_out)
   );

   // output register: pick the scoring mode
   logic               rsp_valid_ff;
   logic [14:0]        lq_ff, cq_ff;
   logic signed [16:0] avg_ff;
   logic [14:0]        lq_in, cq_in;
   logic signed [16:0] avg_in;

   always_comb begin
      lq_in  = simp_ff ? r2m_side_out.lq_lin : mos_pair[0];
      cq_in  = simp_ff ? r2m_side_out.cq_lin : mos_pair[1];
      avg_in = simp_ff ? $signed(17'((16'(r2m_side_out.lq_lin) + 16'd8) >> 4))
                       : r2m_side_out.r_lq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= r2m_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lq_ff  <= lq_in;
         cq_ff  <= cq_in;
         avg_ff <= avg_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_mos_listening      = lq_ff;
   assign rsp_mos_conversational = cq_ff;
   assign rsp_average_quantity   = avg_ff;

endmodule

`default_nettype wire

// ----- rtl/vms_checker.sv -----
// vms_checker: port-level checks on the voice quality score unit, bound to
// the top level. Depends on voip_mos_score_unit's ports only.
`default_nettype none

module vms_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [14:0]        rsp_mos_listening,
   input wire logic [14:0]        rsp_mos_conversational,
   input wire logic signed [16:0] rsp_average_quantity
);

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mos_listening)
         && $stable(rsp_mos_conversational) && $stable(rsp_average_quantity))
      else $error("result beat changed while stalled");

   // both scores stay on the MOS scale
   a_mos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mos_listening >= 15'd4096 && rsp_mos_listening <= 15'd18432
         && rsp_mos_conversational >= 15'd4096 && rsp_mos_conversational <= 15'd18432)
      else $error("MOS out of range");

   // delay only ever lowers the score
   a_cq_le_lq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mos_conversational <= rsp_mos_listening)
      else $error("conversational MOS above listening MOS");

   // the request side stalls only behind a held result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled with no held result");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind voip_mos_score_unit vms_checker u_checker (.*);

`default_nettype wire

// ----- tb/tb_voip_mos_score_unit.sv -----
// tb_voip_mos_score_unit: self-checking bench for the voice quality score pipeline.
// Drives scored samples under several register settings, predicts each score inline
// and checks every result beat in order. Depends on vms_pkg and voip_mos_score_unit.
`default_nettype none

module tb_voip_mos_score_unit;

   typedef struct {
      logic [14:0] loss;
      logic [15:0] jitter;
      logic [15:0] depth;
      logic [15:0] rtt;
   } sample_type;

   typedef struct {
      logic [14:0]        lq;
      logic [14:0]        cq;
      logic signed [16:0] avg;
   } score_type;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_WAIT  = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic [14:0] req_loss_percent = '0;
   logic [15:0] req_jitter_time = '0, req_buffer_depth = '0, req_round_trip = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic [14:0] rsp_mos_listening, rsp_mos_conversational;
   logic signed [16:0] rsp_average_quantity;
   logic csr_valid = 1'b0, csr_ready;
   logic [1:0] csr_index = '0;
   logic [14:0] csr_data = '0;

   sample_type samples_pending[$];
   score_type  scores_due[$];
   int n_queued = 0, n_taken = 0, n_scored = 0, n_errors = 0, n_cycles = 0;
   int phase = 0, hold_left = 0;
   bit hold_done = 1'b0;
   logic req_taken = 1'b0;

   logic        cfg_simple = 1'b0, cfg_wb = 1'b0;
   logic [14:0] cfg_ie = 15'd0, cfg_bpl = 15'd1101;

   voip_mos_score_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [14:0] clip_mos(longint m);
      if (m < vms_pkg::MOS_ONE) return vms_pkg::MOS_ONE;
      if (m > vms_pkg::MOS_MAX) return vms_pkg::MOS_MAX;
      return m[14:0];
   endfunction

   // G.107 R to MOS polynomial, numerator over 1e6 * 2^24
   function automatic logic [14:0] mos_of_r(longint r, logic wb);
      longint rr, num;
      if (r <= 0) return vms_pkg::MOS_ONE;
      rr = wb ? (r * 100 + 64) / 129 : r;
      if (rr <= 0) return vms_pkg::MOS_ONE;
      if (rr >= 25600) return vms_pkg::MOS_MAX;
      num = 64'sd4096000000 * 64'sd16777216 + 64'sd143360000 * rr * 64'sd65536
          + 64'sd28672 * rr * (rr - 15360) * (25600 - rr);
      if (num <= 0) return vms_pkg::MOS_ONE;
      return clip_mos((num + 64'sd8388608000000) / 64'sd16777216000000);
   endfunction

   function automatic logic [14:0] linear_mos(longint num);
      if (num <= 64'sd40960000) return vms_pkg::MOS_ONE;
      return clip_mos((num + 5000) / 10000);
   endfunction

   function automatic score_type score_sample(sample_type s);
      score_type e;
      longint loss, ie, bpl, den, ie_eff, r_lq, ta, idn, id, lnum;
      loss = (s.loss > vms_pkg::LOSS_MAX) ? longint'(vms_pkg::LOSS_MAX)
                                          : longint'(s.loss);
      if (cfg_simple) begin
         lnum = 64'sd184320000 - 14400 * loss - 2304 * longint'(s.jitter);
         e.lq = linear_mos(lnum);
         e.cq = linear_mos(lnum - 1280 * longint'(s.rtt));
         e.avg = 17'((longint'(e.lq) + 8) >>> 4);
      end else begin
         ie = (cfg_ie > vms_pkg::IE_MAX) ? longint'(vms_pkg::IE_MAX) : longint'(cfg_ie);
         bpl = (cfg_bpl < 1) ? 1 : longint'(cfg_bpl);
         den = loss + bpl;
         ie_eff = ie + ((longint'(vms_pkg::IE_MAX) - ie) * loss + den / 2) / den;
         r_lq = (cfg_wb ? longint'(vms_pkg::RO_WB) : longint'(vms_pkg::RO_NB)) - ie_eff;
         ta = longint'(s.rtt) + 2 * longint'(s.depth);
         idn = 960 * ta;
         if (ta * 10 > 56736) idn += 440 * (ta * 10 - 56736);
         id = (idn + 2500) / 5000;
         e.lq = mos_of_r(r_lq, cfg_wb);
         e.cq = mos_of_r(r_lq - id, cfg_wb);
         e.avg = 17'(r_lq);
      end
      return e;
   endfunction

   // Sender: hold each beat until taken, idle at random outside the quiet phase
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (samples_pending.size() > 0 &&
             !(phase != 3 && $urandom_range(99) < 36)) begin
            sample_type s;
            s = samples_pending.pop_front();
            req_loss_percent <= s.loss;
            req_jitter_time  <= s.jitter;
            req_buffer_depth <= s.depth;
            req_round_trip   <= s.rtt;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: one long hold-off in the stall phase, random idling outside the quiet phase
   always @(negedge clock) begin
      if (phase == 2 && !hold_done && hold_left == 0) begin
         hold_left <= 300;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(phase != 3 && $urandom_range(99) < 36);
      end
   end

   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("voip_mos_score_unit: mismatch");
         $finish;
      end
      req_taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         sample_type s;
         s.loss = req_loss_percent;
         s.jitter = req_jitter_time;
         s.depth = req_buffer_depth;
         s.rtt = req_round_trip;
         scores_due.push_back(score_sample(s));
         n_taken <= n_taken + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         score_type e;
         n_scored <= n_scored + 1;
         if (scores_due.size() == 0) begin
            $error("result beat with no score due");
            n_errors++;
         end else begin
            e = scores_due.pop_front();
            if (rsp_mos_listening !== e.lq) begin
               $error("mos_listening: expected %0d, got %0d", e.lq, rsp_mos_listening);
               n_errors++;
            end
            if (rsp_mos_conversational !== e.cq) begin
               $error("mos_conversational: expected %0d, got %0d",
                      e.cq, rsp_mos_conversational);
               n_errors++;
            end
            if (rsp_average_quantity !== e.avg) begin
               $error("average_quantity: expected %0d, got %0d",
                      e.avg, rsp_average_quantity);
               n_errors++;
            end
         end
      end
   end

   task automatic add_sample(int loss, int jitter, int depth, int rtt);
      sample_type s;
      s.loss = loss[14:0];
      s.jitter = jitter[15:0];
      s.depth = depth[15:0];
      s.rtt = rtt[15:0];
      samples_pending.push_back(s);
      n_queued++;
   endtask

   task automatic add_random(int count);
      int loss, pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 70) loss = $urandom_range(1500);
         else if (pick < 90) loss = $urandom_range(25600);
         else loss = $urandom_range(32767);
         add_sample(loss,
                    ($urandom_range(9) < 6) ? $urandom_range(8000) : $urandom_range(65535),
                    ($urandom_range(9) < 6) ? $urandom_range(8000) : $urandom_range(65535),
                    ($urandom_range(9) < 6) ? $urandom_range(8000) : $urandom_range(65535));
      end
   endtask

   // Drain: every queued sample taken and scored, then let the pipe empty
   task automatic drain;
      do @(negedge clock);
      while (samples_pending.size() != 0 || n_taken != n_queued || scores_due.size() != 0);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(vms_pkg::csr_index_type idx, int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[14:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         vms_pkg::CSR_SIMPLIFIED: cfg_simple = value[0];
         vms_pkg::CSR_WIDEBAND:   cfg_wb = value[0];
         vms_pkg::CSR_CODEC_IE:   cfg_ie = value[14:0];
         vms_pkg::CSR_LOSS_BPL:   cfg_bpl = value[14:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(int simple, int wb, int ie, int bpl);
      write_reg(vms_pkg::CSR_SIMPLIFIED, simple);
      write_reg(vms_pkg::CSR_WIDEBAND, wb);
      write_reg(vms_pkg::CSR_CODEC_IE, ie);
      write_reg(vms_pkg::CSR_LOSS_BPL, bpl);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Defaults: narrowband E-model, field extremes and loss saturation
      add_sample(0, 0, 0, 0);
      add_sample(25600, 65535, 65535, 65535);
      add_sample(32767, 0, 0, 0);
      add_sample(25601, 0, 0, 0);
      add_sample(0, 0, 2837, 0);
      add_sample(0, 0, 2837, 1);
      add_sample(256, 0, 0, 11348);
      add_sample(5000, 0, 0, 40000);
      drain();

      // Wideband with Ie and Bpl past their limits
      set_regs(0, 1, 32767, 0);
      add_sample(0, 0, 0, 0);
      add_sample(32767, 65535, 65535, 65535);
      add_sample(100, 0, 100, 100);
      drain();
      set_regs(0, 1, 0, 16384);
      add_sample(0, 0, 0, 0);
      add_sample(0, 0, 0, 4000);
      add_sample(25600, 0, 0, 0);
      drain();

      // Linear formula at both ends and the floor
      set_regs(1, 0, 0, 1101);
      add_sample(0, 0, 0, 0);
      add_sample(32767, 65535, 65535, 65535);
      add_sample(0, 65535, 0, 0);
      add_sample(0, 0, 0, 65535);
      add_sample(1000, 2000, 0, 3000);
      add_random(60);
      drain();

      phase = 1;
      set_regs(0, 0, $urandom_range(4000), $urandom_range(1, 3000));
      add_random(70);
      drain();

      // Receiver holds off while the sender keeps offering
      phase = 2;
      set_regs(0, 1, $urandom_range(32767), $urandom_range(32767));
      add_random(80);
      drain();

      phase = 3;
      set_regs(1, 1, $urandom_range(32767), $urandom_range(32767));
      add_random(70);
      drain();

      phase = 4;
      set_regs(0, 0, 24320, 1);
      add_random(60);
      drain();
      set_regs($urandom_range(1), $urandom_range(1), $urandom_range(32767),
               $urandom_range(32767));
      add_random(60);
      drain();

      $display("Scored %0d samples over E-model, wideband and linear settings,", n_scored);
      $display("with a long result stall and a stretch of back-to-back beats.");
      if (n_errors == 0) begin
         $display("voip_mos_score_unit: match");
      end else begin
         $display("voip_mos_score_unit: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
